@@ rtl/pcsb_pkg.sv @@
// Shared widths, status codes and register map of the coincidence sinogram binner.
`default_nettype none

package pcsb_pkg;

  // Fixed payload widths
  localparam int CRYSTAL_W = 6;
  localparam int BLOCK_W   = 3;
  localparam int SECTOR_W  = 6;
  localparam int STATUS_W  = 2;
  localparam int RING_W    = 5;
  localparam int BIN_W     = 9;
  localparam int ADDR_W    = 25;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int MAX_RD_W = 5;
  localparam logic [MAX_RD_W-1:0] MAX_RD_RESET = 5'd11;
  localparam logic REG_MAX_RING_DIFF = 1'b0;

  // Result status
  typedef enum logic [STATUS_W-1:0] {
    STATUS_BINNED    = 2'd0,
    STATUS_RING_DIFF = 2'd1,
    STATUS_RADIAL    = 2'd2,
    STATUS_GEOMETRY  = 2'd3
  } status_t;

endpackage

`default_nettype wire

@@ rtl/pcsb_hit_decode.sv @@
// Decodes one hit into its ring number and its crystal index around the ring.
`default_nettype none

module pcsb_hit_decode #(
  parameter int CRYSTALS_TANGENTIAL = 6,
  parameter int CRYSTALS_AXIAL      = 6,
  parameter int MODULES_TANGENTIAL  = 2,
  parameter int DETECTORS_PER_RING  = 672,
  parameter int RING_COUNT          = 18,
  parameter int RW                  = 6,
  parameter int DW                  = 12
) (
  input  wire logic [pcsb_pkg::CRYSTAL_W-1:0] crystal,
  input  wire logic [pcsb_pkg::BLOCK_W-1:0]   block,
  input  wire logic [pcsb_pkg::SECTOR_W-1:0]  sector,
  output logic [RW-1:0]                       ring,
  output logic [DW-1:0]                       det,
  output logic                                outside
);
  import pcsb_pkg::*;

  localparam int CRY_N = 2 ** CRYSTAL_W;
  localparam int BLK_N = 2 ** BLOCK_W;

  // Quotient and remainder tables, filled at elaboration
  logic [CRYSTAL_W-1:0] cry_q_tbl [CRY_N];
  logic [CRYSTAL_W-1:0] cry_r_tbl [CRY_N];
  logic [BLOCK_W-1:0]   blk_q_tbl [BLK_N];
  logic [BLOCK_W-1:0]   blk_r_tbl [BLK_N];

  for (genvar g = 0; g < CRY_N; g++) begin : g_cry_tbl
    assign cry_q_tbl[g] = CRYSTAL_W'(g / CRYSTALS_TANGENTIAL);
    assign cry_r_tbl[g] = CRYSTAL_W'(g % CRYSTALS_TANGENTIAL);
  end

  for (genvar g = 0; g < BLK_N; g++) begin : g_blk_tbl
    assign blk_q_tbl[g] = BLOCK_W'(g / MODULES_TANGENTIAL);
    assign blk_r_tbl[g] = BLOCK_W'(g % MODULES_TANGENTIAL);
  end

  // Axial position gives the ring, tangential position the crystal index
  assign ring = RW'(32'(cry_q_tbl[crystal]) + 32'(blk_q_tbl[block]) * CRYSTALS_AXIAL);
  assign det  = DW'(32'(sector) * (MODULES_TANGENTIAL * CRYSTALS_TANGENTIAL)
                    + 32'(blk_r_tbl[block]) * CRYSTALS_TANGENTIAL
                    + 32'(cry_r_tbl[crystal]));

  // Hit beyond the scanner geometry
  assign outside = (32'(ring) >= RING_COUNT) || (32'(det) >= DETECTORS_PER_RING);

endmodule

`default_nettype wire

@@ rtl/pet_coincidence_sinogram_binner_core.sv @@
// Beats pass stage registers 1 to 5, then the output registers. Throughput: one
// coincidence per cycle while not stalled; six register stages, each stage moves when
// its successor is empty or moving, so bubbles collapse under an output stall.
// The address multiply-add chain (ring pair, angle, radial) sets the stage count.
// Reset: synchronous; clears all stage valid bits and sets max_ring_difference to 11.
`default_nettype none

module pet_coincidence_sinogram_binner_core #(
  parameter int CRYSTALS_TANGENTIAL = 6,
  parameter int CRYSTALS_AXIAL      = 6,
  parameter int MODULES_TANGENTIAL  = 2,
  parameter int DETECTORS_PER_RING  = 672,
  parameter int RADIAL_BINS         = 283,
  parameter int RING_COUNT          = 18
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pcsb_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [pcsb_pkg::PDATA_W-1:0]   pwdata,
  output logic [pcsb_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pcsb_pkg::CRYSTAL_W-1:0] crystal_a,
  input  wire logic [pcsb_pkg::BLOCK_W-1:0]   block_a,
  input  wire logic [pcsb_pkg::SECTOR_W-1:0]  sector_a,
  input  wire logic [pcsb_pkg::CRYSTAL_W-1:0] crystal_b,
  input  wire logic [pcsb_pkg::BLOCK_W-1:0]   block_b,
  input  wire logic [pcsb_pkg::SECTOR_W-1:0]  sector_b,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pcsb_pkg::STATUS_W-1:0]       status,
  output logic [pcsb_pkg::RING_W-1:0]         ring_first,
  output logic [pcsb_pkg::RING_W-1:0]         ring_second,
  output logic [pcsb_pkg::BIN_W-1:0]          angle_bin,
  output logic [pcsb_pkg::BIN_W-1:0]          radial_bin,
  output logic [pcsb_pkg::ADDR_W-1:0]         hist_address
);
  import pcsb_pkg::*;

  // Derived geometry and widths
  localparam int D       = DETECTORS_PER_RING;
  localparam int HALF    = D / 2;
  localparam int QUARTER = D / 4;
  localparam int U_OFS   = RADIAL_BINS / 2;
  localparam int R_MAX   = 63 / CRYSTALS_TANGENTIAL + (7 / MODULES_TANGENTIAL) * CRYSTALS_AXIAL;
  localparam int D_MAX   = 63 * MODULES_TANGENTIAL * CRYSTALS_TANGENTIAL
                           + 7 * CRYSTALS_TANGENTIAL + 63;
  localparam int RAW_RW  = $clog2(R_MAX + 1);
  localparam int RAW_DW  = $clog2(D_MAX + 1);
  localparam int RRW     = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
  localparam int DRW     = $clog2(D);
  localparam int PHW     = $clog2(HALF + 1);
  localparam int UW      = $clog2(D + RADIAL_BINS + 1) + 1;
  localparam int URW     = $clog2(RADIAL_BINS);
  localparam int ZW      = $clog2(2 * D + 2) + 1;
  localparam int M1W     = $clog2(RING_COUNT * RING_COUNT + 1);

  // Configuration register
  logic [MAX_RD_W-1:0] max_rd;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_RING_DIFF);
  assign prdata    = (paddr[2] == REG_MAX_RING_DIFF) ? PDATA_W'(max_rd) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rd <= MAX_RD_RESET;
    end else if (cfg_write) begin
      max_rd <= pwdata[MAX_RD_W-1:0];
    end
  end

  // Stage enables: a stage loads when empty or when its successor loads
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  assign en6      = !v6 || !out_stall;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // Stage 1: hit decode
  logic [RAW_RW-1:0] ring_a, ring_b;
  logic [RAW_DW-1:0] det_a, det_b;
  logic              outside_a, outside_b;

  pcsb_hit_decode #(
    .CRYSTALS_TANGENTIAL(CRYSTALS_TANGENTIAL), .CRYSTALS_AXIAL(CRYSTALS_AXIAL),
    .MODULES_TANGENTIAL(MODULES_TANGENTIAL), .DETECTORS_PER_RING(DETECTORS_PER_RING),
    .RING_COUNT(RING_COUNT), .RW(RAW_RW), .DW(RAW_DW)
  ) u_hit_a (
    .crystal(crystal_a), .block(block_a), .sector(sector_a),
    .ring(ring_a), .det(det_a), .outside(outside_a)
  );

  pcsb_hit_decode #(
    .CRYSTALS_TANGENTIAL(CRYSTALS_TANGENTIAL), .CRYSTALS_AXIAL(CRYSTALS_AXIAL),
    .MODULES_TANGENTIAL(MODULES_TANGENTIAL), .DETECTORS_PER_RING(DETECTORS_PER_RING),
    .RING_COUNT(RING_COUNT), .RW(RAW_RW), .DW(RAW_DW)
  ) u_hit_b (
    .crystal(crystal_b), .block(block_b), .sector(sector_b),
    .ring(ring_b), .det(det_b), .outside(outside_b)
  );

  logic [RRW-1:0] s1_r1, s1_r2;
  logic [DRW-1:0] s1_d1, s1_d2;
  logic           s1_outside;

  // Out-of-geometry hits are flagged; their truncated fields are never used
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r1      <= RRW'(ring_a);
      s1_r2      <= RRW'(ring_b);
      s1_d1      <= DRW'(det_a);
      s1_d2      <= DRW'(det_b);
      s1_outside <= outside_a || outside_b;
    end
  end

  // Stage 2: ring difference check, sum, difference, angle bin
  logic [RRW-1:0]        ring_diff;
  logic                  too_far;
  logic [DRW:0]          sum_c;
  logic signed [DRW:0]   diff_c;
  logic [DRW-1:0]        absdiff_c;
  logic [DRW+1:0]        psum;
  logic [DRW-1:0]        pmod;
  logic                  inside_c;
  status_t               status2_c;

  always_comb begin
    ring_diff = (s1_r1 >= s1_r2) ? s1_r1 - s1_r2 : s1_r2 - s1_r1;
    too_far   = 32'(ring_diff) > 32'(max_rd);
    sum_c     = {1'b0, s1_d1} + {1'b0, s1_d2};
    diff_c    = $signed({1'b0, s1_d1}) - $signed({1'b0, s1_d2});
    absdiff_c = diff_c[DRW] ? DRW'(-diff_c) : DRW'(diff_c);
    // (sum + half) mod D, operand below three times D
    psum      = (DRW+2)'(sum_c) + (DRW+2)'(HALF);
    if (32'(psum) >= 2 * D) begin
      pmod = DRW'(32'(psum) - 2 * D);
    end else if (32'(psum) >= D) begin
      pmod = DRW'(32'(psum) - D);
    end else begin
      pmod = DRW'(psum);
    end
    inside_c  = (32'(sum_c) < (3 * D) / 2) && (32'(sum_c) >= HALF);
    if (s1_outside) begin
      status2_c = STATUS_GEOMETRY;
    end else if (too_far) begin
      status2_c = STATUS_RING_DIFF;
    end else begin
      status2_c = STATUS_BINNED;
    end
  end

  logic [RRW-1:0]      s2_r1, s2_r2;
  logic [DRW-1:0]      s2_d1, s2_d2;
  logic signed [DRW:0] s2_diff;
  logic [DRW-1:0]      s2_absdiff;
  logic [PHW-1:0]      s2_phi;
  logic                s2_inside;
  status_t             s2_status;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_r1      <= s1_r1;
      s2_r2      <= s1_r2;
      s2_d1      <= s1_d1;
      s2_d2      <= s1_d2;
      s2_diff    <= diff_c;
      s2_absdiff <= absdiff_c;
      s2_phi     <= PHW'(pmod >> 1);
      s2_inside  <= inside_c;
      s2_status  <= status2_c;
    end
  end

  // Stage 3: radial bin, range check, half-angle shift
  logic signed [UW-1:0] u_abs;
  logic signed [UW-1:0] u_c;
  logic                 u_ok;
  logic                 u_even;
  logic signed [ZW-1:0] zx;
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] zt;
  logic signed [ZW-1:0] zadj;
  logic signed [ZW-1:0] z1;
  logic signed [ZW-1:0] z2;
  status_t              status3_c;

  always_comb begin
    u_abs = $signed(UW'(s2_absdiff));
    if (s2_inside) begin
      u_c = u_abs - $signed(UW'(HALF)) + $signed(UW'(U_OFS));
    end else begin
      u_c = $signed(UW'(HALF)) + $signed(UW'(U_OFS)) - u_abs;
    end
    u_ok   = !u_c[UW-1] && (32'(u_c[UW-2:0]) < RADIAL_BINS);
    u_even = !u_c[0];
    // truncating halving: bias negative values by one before the shift
    zx   = $signed(ZW'(HALF)) - ZW'(s2_diff) - $signed(ZW'(u_even));
    zr   = zx + $signed(ZW'(zx[ZW-1]));
    zt   = zr >>> 1;
    zadj = u_even ? $signed(ZW'(HALF - 1)) : $signed(ZW'(HALF));
    z1   = (zt >= $signed(ZW'(QUARTER))) ? zt - zadj : zt;
    z2   = (z1 <= $signed(ZW'(-QUARTER))) ? z1 + zadj : z1;
    if ((s2_status == STATUS_BINNED) && !u_ok) begin
      status3_c = STATUS_RADIAL;
    end else begin
      status3_c = s2_status;
    end
  end

  logic [RRW-1:0]       s3_r1, s3_r2;
  logic [DRW-1:0]       s3_d1, s3_d2;
  logic signed [ZW-1:0] s3_zi;
  logic [PHW-1:0]       s3_phi;
  logic [URW-1:0]       s3_u;
  status_t              s3_status;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_r1     <= s2_r1;
      s3_r2     <= s2_r2;
      s3_d1     <= s2_d1;
      s3_d2     <= s2_d2;
      s3_zi     <= z2;
      s3_phi    <= s2_phi;
      s3_u      <= URW'(u_c);
      s3_status <= status3_c;
    end
  end

  // Stage 4: shifted crystals, ring pair ordering, ring part of address
  function automatic logic [DRW-1:0] wrap_det(input logic signed [ZW:0] e);
    logic [DRW-1:0] w;
    if (e < 0) begin
      w = DRW'(e + $signed((ZW+1)'(D)));
    end else if (e >= $signed((ZW+1)'(D))) begin
      w = DRW'(e - $signed((ZW+1)'(D)));
    end else begin
      w = DRW'(e);
    end
    return w;
  endfunction

  logic signed [ZW:0] e1, e2;
  logic [DRW-1:0]     w1, w2;
  logic [RRW-1:0]     first_c, second_c;

  always_comb begin
    e1 = $signed((ZW+1)'(s3_d1)) + (ZW+1)'(s3_zi);
    e2 = $signed((ZW+1)'(s3_d2)) - (ZW+1)'(s3_zi);
    w1 = wrap_det(e1);
    w2 = wrap_det(e2);
    if (w1 >= w2) begin
      first_c  = s3_r1;
      second_c = s3_r2;
    end else begin
      first_c  = s3_r2;
      second_c = s3_r1;
    end
  end

  logic [RRW-1:0] s4_first, s4_second;
  logic [M1W-1:0] s4_m1;
  logic [PHW-1:0] s4_phi;
  logic [URW-1:0] s4_u;
  status_t        s4_status;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_first  <= first_c;
      s4_second <= second_c;
      s4_m1     <= M1W'(32'(first_c) * RING_COUNT + 32'(second_c));
      s4_phi    <= s3_phi;
      s4_u      <= s3_u;
      s4_status <= s3_status;
    end
  end

  // Stage 5: fold in the angle bin
  logic [RRW-1:0]    s5_first, s5_second;
  logic [ADDR_W-1:0] s5_m2;
  logic [PHW-1:0]    s5_phi;
  logic [URW-1:0]    s5_u;
  status_t           s5_status;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_first  <= s4_first;
      s5_second <= s4_second;
      s5_m2     <= ADDR_W'(64'(s4_m1) * HALF + 64'(s4_phi));
      s5_phi    <= s4_phi;
      s5_u      <= s4_u;
      s5_status <= s4_status;
    end
  end

  // Stage 6: fold in the radial bin; rejected beats carry zero fields
  logic binned5;
  assign binned5 = (s5_status == STATUS_BINNED);

  always_ff @(posedge clk) begin
    if (en6) begin
      status       <= s5_status;
      ring_first   <= binned5 ? RING_W'(s5_first) : '0;
      ring_second  <= binned5 ? RING_W'(s5_second) : '0;
      angle_bin    <= binned5 ? BIN_W'(s5_phi) : '0;
      radial_bin   <= binned5 ? BIN_W'(s5_u) : '0;
      hist_address <= binned5 ? ADDR_W'(64'(s5_m2) * RADIAL_BINS + 64'(s5_u)) : '0;
    end
  end

  // Checks
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side is free");

  a_radial_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_BINNED) |-> (32'(radial_bin) < RADIAL_BINS))
    else $error("binned beat with radial bin out of range");

  a_rejected_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_BINNED) |->
      (hist_address == '0 && angle_bin == '0 && ring_first == '0))
    else $error("rejected beat carries nonzero fields");

endmodule

`default_nettype wire
